// File: rtl/rpc_pkg.sv
// ============================================================================
// rpc_pkg - shared types and constants for the rectangular/polar converter
// Beat types, datapath widths, CORDIC angle table and gain constant.
// ============================================================================
`default_nettype none

package rpc_pkg;

    localparam int MAX_STAGES = 32;
    localparam int STAGES_DEF = 24;

    // internal coordinate width: Q20.12 input, 16 guard bits, CORDIC growth
    localparam int DW    = 52;
    localparam int GUARD = 16;
    localparam int RW    = DW - GUARD;

    localparam logic [29:0] INV_GAIN = 30'd652032874;

    localparam logic CMD_TO_POLAR = 1'b0;
    localparam logic CMD_TO_RECT  = 1'b1;

    localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] first_in;
        logic signed [31:0] second_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] first_out;
        logic signed [31:0] second_out;
    } out_beat_t;

    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               zero;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic        [31:0] z;
    } stage_t;

endpackage

`default_nettype wire

// File: rtl/rpc_pre.sv
// ============================================================================
// rpc_pre - input conditioning
// Quadrant fold and guard-bit scaling for vectoring; half-plane fold and
// gain pre-compensation (one multiply, then rounding) for rotation.
// ============================================================================
`default_nettype none

module rpc_pre
    import rpc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire in_beat_t in_data,
    output stage_t        out
);

    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               zero;
        logic signed [63:0] acc;
        logic signed [DW-1:0] y;
        logic        [31:0] z;
    } pre_t;

    pre_t   p1_reg, p1_next;
    stage_t out_reg, out_next;

    logic               neg;
    logic signed [32:0] re_abs, im_abs;
    logic               flip;
    logic signed [30:0] gain;
    logic signed [63:0] prod;
    logic signed [63:0] acc_rnd;

    always_comb begin
        neg    = in_data.first_in[31];
        re_abs = neg ? -{in_data.first_in[31], in_data.first_in}
                     :  {in_data.first_in[31], in_data.first_in};
        im_abs = neg ? -{in_data.second_in[31], in_data.second_in}
                     :  {in_data.second_in[31], in_data.second_in};
        flip   = in_data.second_in[31] ^ in_data.second_in[30];
        gain   = flip ? -$signed({1'b0, INV_GAIN}) : $signed({1'b0, INV_GAIN});
        prod   = in_data.first_in * gain;

        p1_next.valid = in_valid;
        p1_next.cmd   = in_data.cmd;
        p1_next.zero  = (in_data.first_in == '0) && (in_data.second_in == '0);
        if (in_data.cmd == CMD_TO_RECT) begin
            p1_next.acc = prod;
            p1_next.y   = '0;
            p1_next.z   = in_data.second_in ^ {flip, 31'b0};
        end else begin
            p1_next.acc = {{(64-33-GUARD){re_abs[32]}}, re_abs, {GUARD{1'b0}}};
            p1_next.y   = {{(DW-33-GUARD){im_abs[32]}}, im_abs, {GUARD{1'b0}}};
            p1_next.z   = {neg, 31'b0};
        end
    end

    always_comb begin
        acc_rnd        = p1_reg.acc + 64'sd8192;
        out_next.valid = p1_reg.valid;
        out_next.cmd   = p1_reg.cmd;
        out_next.zero  = p1_reg.zero;
        out_next.x     = (p1_reg.cmd == CMD_TO_RECT)
                         ? {{(DW-50){acc_rnd[63]}}, acc_rnd[63:14]}
                         : p1_reg.acc[DW-1:0];
        out_next.y     = p1_reg.y;
        out_next.z     = p1_reg.z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid  <= 1'b0;
            out_reg.valid <= 1'b0;
        end else if (en) begin
            p1_reg  <= p1_next;
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

`default_nettype wire

// File: rtl/rpc_cell.sv
// ============================================================================
// rpc_cell - one CORDIC micro-rotation
// Fixed shift and angle per position in the chain; direction from the sign
// of y (vectoring) or z (rotation).
// ============================================================================
`default_nettype none

module rpc_cell
    import rpc_pkg::*;
#(
    parameter int STAGE = 0
)(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire stage_t in,
    output stage_t      out
);

    stage_t out_reg, out_next;

    logic               turn_pos;
    logic signed [DW-1:0] xs, ys;

    always_comb begin
        turn_pos = (in.cmd == CMD_TO_RECT) ? !in.z[31] : in.y[DW-1];
        xs       = in.x >>> STAGE;
        ys       = in.y >>> STAGE;
        out_next = in;
        if (turn_pos) begin
            out_next.x = in.x - ys;
            out_next.y = in.y + xs;
            out_next.z = in.z - ATAN_TAB[STAGE];
        end else begin
            out_next.x = in.x + ys;
            out_next.y = in.y - xs;
            out_next.z = in.z + ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

`default_nettype wire

// File: rtl/rpc_post.sv
// ============================================================================
// rpc_post - output scaling
// Drops guard bits, applies gain compensation to the magnitude, saturates
// and holds the result beat in the output register.
// ============================================================================
`default_nettype none

module rpc_post
    import rpc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire stage_t in,
    output logic        out_valid,
    output out_beat_t   out_data
);

    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               zero;
        logic signed [RW-1:0] xr;
        logic signed [RW-1:0] yr;
        logic        [31:0] z;
    } rnd_t;

    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               zero;
        logic        [62:0] prod;
        logic signed [RW-1:0] xr;
        logic signed [RW-1:0] yr;
        logic        [31:0] z;
    } mul_t;

    rnd_t      p1_reg, p1_next;
    mul_t      p2_reg, p2_next;
    logic      valid_reg, valid_next;
    out_beat_t data_reg, data_next;
    logic      cmd_reg, zero_reg;

    logic signed [DW-1:0] x_sum, y_sum;
    logic        [32:0] xc;
    logic        [62:0] prod_rnd;
    logic        [32:0] mag;

    function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
        logic signed [31:0] r;
        if (v > $signed(RW'(32'h7FFFFFFF))) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -$signed(RW'(33'h080000000))) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        x_sum         = in.x + $signed(DW'(1 << (GUARD - 1)));
        y_sum         = in.y + $signed(DW'(1 << (GUARD - 1)));
        p1_next.valid = in.valid;
        p1_next.cmd   = in.cmd;
        p1_next.zero  = in.zero;
        p1_next.xr    = x_sum[DW-1:GUARD];
        p1_next.yr    = y_sum[DW-1:GUARD];
        p1_next.z     = in.z;
    end

    always_comb begin
        if (p1_reg.xr[RW-1]) begin
            xc = '0;
        end else if (p1_reg.xr[RW-2:32] != '0) begin
            xc = 33'h100000000;
        end else begin
            xc = p1_reg.xr[32:0];
        end
        p2_next.valid = p1_reg.valid;
        p2_next.cmd   = p1_reg.cmd;
        p2_next.zero  = p1_reg.zero;
        p2_next.prod  = xc * INV_GAIN;
        p2_next.xr    = p1_reg.xr;
        p2_next.yr    = p1_reg.yr;
        p2_next.z     = p1_reg.z;
    end

    always_comb begin
        prod_rnd   = p2_reg.prod + 63'(1 << 29);
        mag        = prod_rnd[62:30];
        valid_next = p2_reg.valid;
        if (p2_reg.cmd == CMD_TO_RECT) begin
            data_next.first_out  = sat32(p2_reg.xr);
            data_next.second_out = sat32(p2_reg.yr);
        end else if (p2_reg.zero) begin
            data_next.first_out  = '0;
            data_next.second_out = '0;
        end else begin
            data_next.first_out  = mag[32:31] != 2'b00 ? 32'sh7FFFFFFF : $signed(mag[31:0]);
            data_next.second_out = p2_reg.z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid <= 1'b0;
            p2_reg.valid <= 1'b0;
            valid_reg    <= 1'b0;
        end else if (en) begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            cmd_reg  <= p2_reg.cmd;
            zero_reg <= p2_reg.zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_mag_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && cmd_reg == CMD_TO_POLAR |-> !data_reg.first_out[31])
        else $error("polar magnitude negative");

    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && cmd_reg == CMD_TO_POLAR && zero_reg
        |-> data_reg.first_out == '0 && data_reg.second_out == '0)
        else $error("zero vector result not zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !en |=> valid_reg && $stable(data_reg))
        else $error("output beat changed while held");

endmodule

`default_nettype wire

// File: rtl/rect_polar_converter.sv
// ============================================================================
// rect_polar_converter - pipelined CORDIC rectangular/polar conversion
// cmd 0: magnitude and atan2 phase; cmd 1: mag*cos and mag*sin.
// ============================================================================
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    in_beat_t  {cmd, first_in, second_in}
//  m_        out  m_valid/m_ready    out_beat_t {first_out, second_out}
//
//  Accepts one beat per cycle unless a result beat waits on m_ready; the registers are
//  2 conditioning, one per CORDIC cell, 3 output incl. the output register.
//  Synchronous active-low reset empties the pipeline.
//  While a result beat waits on m_ready the whole chain freezes and s_ready
//  is low; with m_valid low or m_ready high the chain advances every cycle.
// ============================================================================
`default_nettype none

module rect_polar_converter
    import rpc_pkg::*;
#(
    parameter int CORDIC_STAGES = STAGES_DEF
)(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    localparam int N = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    logic   en;
    stage_t chain [N+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rpc_pre u_pre (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out      (chain[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        rpc_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in      (chain[g]),
            .out     (chain[g+1])
        );
    end

    rpc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in        (chain[N]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_stall_keeps_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// File: tb/rect_polar_converter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rect_polar_converter_tb - self-checking bench for the CORDIC converter
// Drives directed and random beats in both directions with random idle and
// back-pressure, predicts every result in fixed point and checks it in order.
// ============================================================================

module rect_polar_converter_tb;

    import rpc_pkg::*;

    localparam int STAGES      = STAGES_DEF;
    localparam int LATENCY     = STAGES + 5;
    localparam int N_RANDOM    = 930;
    localparam int MAX_GAP     = 18;
    localparam int CYCLE_LIMIT = 400000;

    class conversion_board;
        out_beat_t expected_conv[$];
        int        n_stages;
        int        n_polar;
        int        n_rect;
        int        n_checked;
        int        n_errors;

        function new(int stages);
            n_stages  = (stages > MAX_STAGES) ? MAX_STAGES : stages;
            n_polar   = 0;
            n_rect    = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function longint round_shr(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function out_beat_t polar_of(longint re, longint im);
            longint    x, y, nx, ny, m;
            bit [31:0] z;
            out_beat_t r;
            int        i;
            z = 32'h0;
            r.first_out  = '0;
            r.second_out = '0;
            if (re == 0 && im == 0)
                return r;
            if (re < 0) begin
                re = -re;
                im = -im;
                z  = 32'h8000_0000;
            end
            x = re <<< GUARD;
            y = im <<< GUARD;
            for (i = 0; i < n_stages; i++) begin
                if (y < 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - ATAN_TAB[i];
                end else begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + ATAN_TAB[i];
                end
                x = nx;
                y = ny;
            end
            m = round_shr(round_shr(x, GUARD) * longint'(INV_GAIN), 30);
            if (m < 0)
                m = 0;
            if (m > 64'sd2147483647)
                m = 64'sd2147483647;
            r.first_out  = m[31:0];
            r.second_out = z;
            return r;
        endfunction

        function out_beat_t rect_of(longint m, bit [31:0] a);
            longint    x, y, z, nx, ny, re, im;
            out_beat_t r;
            int        i;
            // fold the left half plane onto the right one
            if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
                a = a + 32'h8000_0000;
                m = -m;
            end
            z = longint'($signed(a));
            x = round_shr(m * longint'(INV_GAIN), 30 - GUARD);
            y = 0;
            for (i = 0; i < n_stages; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - longint'(ATAN_TAB[i]);
                end else begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + longint'(ATAN_TAB[i]);
                end
                x = nx;
                y = ny;
            end
            re = clamp32(round_shr(x, GUARD));
            im = clamp32(round_shr(y, GUARD));
            r.first_out  = re[31:0];
            r.second_out = im[31:0];
            return r;
        endfunction

        function void note_element(in_beat_t b);
            longint a, c;
            a = longint'($signed(b.first_in));
            c = longint'($signed(b.second_in));
            if (b.cmd == CMD_TO_POLAR) begin
                expected_conv = {expected_conv, polar_of(a, c)};
                n_polar++;
            end else begin
                expected_conv = {expected_conv, rect_of(a, b.second_in)};
                n_rect++;
            end
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, what, exp_v, got_v);
        endfunction

        function void check_conversion(out_beat_t got);
            out_beat_t exp_b;
            if (expected_conv.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
                return;
            end
            exp_b = expected_conv.pop_front();
            n_checked++;
            if (got.first_out !== exp_b.first_out)
                flag("first_out", exp_b.first_out, got.first_out);
            if (got.second_out !== exp_b.second_out)
                flag("second_out", exp_b.second_out, got.second_out);
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    conversion_board board = new(STAGES);
    bit        tx_quiet = 1'b0;
    bit        rx_quiet = 1'b0;
    int        cycle_count = 0;
    in_beat_t  directed[$];

    rect_polar_converter #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_element(s_data);
            if (m_valid && m_ready)
                board.check_conversion(m_data);
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // result side: one stall draw per beat
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_element(in_beat_t b);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic in_beat_t mk(logic c, logic [31:0] a, logic [31:0] b);
        in_beat_t r;
        r.cmd       = c;
        r.first_in  = a;
        r.second_in = b;
        return r;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic in_beat_t random_element();
        in_beat_t    b;
        logic [31:0] t;
        int          kind;
        b.cmd = 1'($urandom_range(0, 1));
        kind  = $urandom_range(0, 9);
        if (kind <= 4) begin
            b.first_in  = $urandom;
            b.second_in = $urandom;
        end else if (kind <= 7) begin
            b.first_in  = $urandom_range(0, 131071) - 65536;
            b.second_in = (b.cmd == CMD_TO_RECT) ? 32'($urandom)
                                                 : 32'($urandom_range(0, 131071) - 65536);
        end else if (kind == 8) begin
            b.first_in  = edge_value();
            b.second_in = ($urandom_range(0, 1) == 0) ? edge_value() : 32'($urandom);
        end else begin
            // phase near a quadrant boundary
            t = 32'($urandom_range(0, 3)) << 30;
            t = t + 32'($urandom_range(0, 8)) - 32'd4;
            b.first_in  = $urandom;
            b.second_in = t;
        end
        return b;
    endfunction

    initial begin
        int i;
        // vectoring corners: zero, saturation, angle of pi, negative real
        directed = {directed, mk(CMD_TO_POLAR, 32'h0000_0000, 32'h0000_0000)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h8000_0000, 32'h8000_0000)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h8000_0000, 32'h0000_0000)};
        directed = {directed, mk(CMD_TO_POLAR, 32'hFFFF_FFFF, 32'h0000_0000)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h0000_0000, 32'h7FFF_FFFF)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h0000_0000, 32'h8000_0000)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h7FFF_FFFF, 32'h0000_0000)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h8000_0000, 32'h7FFF_FFFF)};
        directed = {directed, mk(CMD_TO_POLAR, 32'h0000_0001, 32'h0000_0001)};
        directed = {directed, mk(CMD_TO_POLAR, -32'sd5, -32'sd7)};
        directed = {directed, mk(CMD_TO_POLAR, 32'sd3 <<< 12, -32'sd4 <<< 12)};
        // rotation: quadrant folding, negative magnitude, output saturation
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'h0000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h8000_0000, 32'h0000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'h4000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'h8000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'hC000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'h3FFF_FFFF)};
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
        directed = {directed, mk(CMD_TO_RECT, 32'h7FFF_FFFF, 32'h2000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h8000_0000, 32'h8000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h8000_0000, 32'h4000_0000)};
        directed = {directed, mk(CMD_TO_RECT, 32'h0000_0000, 32'hFFFF_FFFF)};
        directed = {directed, mk(CMD_TO_RECT, 32'h0000_1000, 32'hBFFF_FFFF)};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[k])
            send_element(directed[k]);
        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            send_element(random_element());
        end
        s_valid <= 1'b0;
        rx_quiet = 1'b0;

        while (board.expected_conv.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);

        $display("Ran %0d beats: %0d rectangular-to-polar, %0d polar-to-rectangular.",
                 board.n_polar + board.n_rect, board.n_polar, board.n_rect);
        $display("Checked %0d result beats, %0d field mismatches.",
                 board.n_checked, board.n_errors);
        if (board.n_errors == 0 && board.expected_conv.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: rect_polar_converter.f
rtl/rpc_pkg.sv
rtl/rpc_pre.sv
rtl/rpc_cell.sv
rtl/rpc_post.sv
rtl/rect_polar_converter.sv
tb/rect_polar_converter_tb.sv
